[hw/rtl/wsll_pkg.sv]
// ----------------------------------------------------------------------------
// wsll_pkg
// Shared types and codes for the worker status table with least-loaded pick.
// ----------------------------------------------------------------------------
package wsll_pkg;

  localparam int TABLE_DEPTH_DEF = 8;
  localparam int ID_WIDTH        = 16;

  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_PICK   = 2'd2;

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_BUSY     = 2'd1;
  localparam logic [1:0] ST_SHUTDOWN = 2'd2;
  localparam logic [1:0] ST_RSVD     = 2'd3;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_NONE = 2'd2;

  localparam logic CFG_MAX_ENTRIES = 1'b0;
  localparam logic CFG_STALE_LIMIT = 1'b1;

  localparam logic [3:0]  MAX_ENTRIES_RST = 4'd3;
  localparam logic [31:0] STALE_LIMIT_RST = 32'd30000;

  typedef struct packed {
    logic [1:0]          op;
    logic [ID_WIDTH-1:0] worker_id;
    logic [1:0]          new_state;
    logic [31:0]         new_queue_size;
    logic [63:0]         new_memory_bytes;
    logic [47:0]         now_ms;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [2:0]          entry_index;
    logic [ID_WIDTH-1:0] chosen_id;
    logic [1:0]          out_state;
    logic [31:0]         out_queue_size;
    logic [63:0]         out_memory_bytes;
    logic [47:0]         out_last_update_ms;
    logic [31:0]         out_request_count;
  } rsp_t;

  typedef struct packed {
    logic [ID_WIDTH-1:0] id;
    logic [1:0]          state;
    logic [31:0]         queue;
    logic [63:0]         mem;
    logic [47:0]         last;
    logic [31:0]         reqs;
  } entry_t;

  // Sweep record handed from cell to cell
  typedef struct packed {
    logic   vld;
    logic   hit;
    logic   idle;
    entry_t ent;
  } scan_t;

  // Request fields broadcast to every cell during a sweep
  typedef struct packed {
    logic [1:0]          op;
    logic [ID_WIDTH-1:0] id;
    logic [47:0]         now;
    logic [31:0]         stale_limit;
  } probe_t;

endpackage

[hw/rtl/wsll_cell.sv]
// ----------------------------------------------------------------------------
// wsll_cell
// One table slot: holds an entry and folds it into the passing sweep record.
// ----------------------------------------------------------------------------
module wsll_cell #(
  parameter int TABLE_DEPTH = wsll_pkg::TABLE_DEPTH_DEF,
  parameter int CELL_IDX    = 0,
  localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  wsll_pkg::probe_t     probe,
  input  logic [CNT_W-1:0]     live_n,
  input  wsll_pkg::scan_t      scan_in,
  input  logic [IDX_W-1:0]     sel_in,
  output wsll_pkg::scan_t      scan_out,
  output logic [IDX_W-1:0]     sel_out,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  wsll_pkg::entry_t     wr_ent
);
  import wsll_pkg::*;

  entry_t           ent;
  scan_t            scan_next;
  logic [IDX_W-1:0] sel_next;
  logic             live;
  logic             stale;
  logic             is_idle;
  logic             q_lt;
  logic             take;
  logic [47:0]      age;

  always_comb begin
    live    = CNT_W'(CELL_IDX) < live_n;
    age     = probe.now - ent.last;
    stale   = (probe.now >= ent.last) && (age > {16'b0, probe.stale_limit});
    is_idle = ent.state == ST_IDLE;
    q_lt    = ent.queue < scan_in.ent.queue;
    take    = 1'b0;
    case (probe.op)
      OP_UPDATE, OP_LOOKUP: begin
        take = live && !scan_in.hit && (ent.id == probe.id);
      end
      OP_PICK: begin
        if (live && (ent.state != ST_SHUTDOWN) && !stale) begin
          if (is_idle) begin
            take = !scan_in.hit || !scan_in.idle || q_lt;
          end else begin
            take = !scan_in.idle && (!scan_in.hit || q_lt);
          end
        end
      end
      default: take = 1'b0;
    endcase
    scan_next = scan_in;
    sel_next  = sel_in;
    if (take) begin
      scan_next.hit  = 1'b1;
      scan_next.idle = is_idle;
      scan_next.ent  = ent;
      sel_next       = IDX_W'(CELL_IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_out <= '0;
      sel_out  <= '0;
    end else begin
      scan_out <= scan_next;
      sel_out  <= sel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IDX_W'(CELL_IDX))) begin
      ent <= wr_ent;
    end
  end

endmodule

[hw/rtl/worker_status_table_least_loaded_core.sv]
// ----------------------------------------------------------------------------
// worker_status_table_least_loaded_core
// Worker status table: update, lookup by id and least-loaded pick.
// ----------------------------------------------------------------------------
// Flow: a request sweeps the row of cells, one cell per cycle; the result is
//   registered in S_HOLD and then in the output register. A new request is
//   taken only after the previous result has been loaded into the output.
// Reset: synchronous; clears the entry count and loads max_entries = 3 and
//   stale_limit_ms = 30000. Entry contents are not cleared.
module worker_status_table_least_loaded_core #(
  parameter int TABLE_DEPTH = wsll_pkg::TABLE_DEPTH_DEF,
  localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  wsll_pkg::req_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output wsll_pkg::rsp_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_index,
  input  logic [31:0]     cfg_data
);
  import wsll_pkg::*;

  localparam int LW = (CNT_W > 4) ? CNT_W : 4;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_HOLD} state_t;

  state_t           state;
  logic [3:0]       max_entries;
  logic [31:0]      stale_limit;
  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] live_n;
  logic             inj_vld;
  req_t             req;
  rsp_t             res;
  logic             res_wr;
  logic             res_app;
  logic [IDX_W-1:0] res_idx;

  probe_t           probe;
  scan_t            chain [0:TABLE_DEPTH];
  logic [IDX_W-1:0] sel   [0:TABLE_DEPTH];
  scan_t            tail;
  logic [IDX_W-1:0] tail_sel;

  logic             accept;
  logic             load;
  logic [LW-1:0]    lim;
  logic             can_app;
  logic [CNT_W-1:0] live_now;
  logic [1:0]       fix_st;
  rsp_t             rsp_next;
  logic             wr_next;
  logic             app_next;
  logic [IDX_W-1:0] idx_next;
  logic             wr_en;
  entry_t           wr_ent;

  assign cfg_ready = 1'b1;
  assign in_stall  = state != S_IDLE;
  assign accept    = in_valid && !in_stall;
  assign load      = (state == S_HOLD) && (!out_valid || !out_stall);

  always_comb begin
    lim      = (LW'(max_entries) > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : LW'(max_entries);
    can_app  = LW'(entry_count) < lim;
    live_now = can_app ? entry_count : CNT_W'(lim);
  end

  always_comb begin
    probe.op          = req.op;
    probe.id          = req.worker_id;
    probe.now         = req.now_ms;
    probe.stale_limit = stale_limit;
  end

  always_comb begin
    chain[0]     = '0;
    chain[0].vld = inj_vld;
    sel[0]       = '0;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    wsll_cell #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .CELL_IDX    (g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .probe    (probe),
      .live_n   (live_n),
      .scan_in  (chain[g]),
      .sel_in   (sel[g]),
      .scan_out (chain[g+1]),
      .sel_out  (sel[g+1]),
      .wr_en    (wr_en),
      .wr_idx   (res_idx),
      .wr_ent   (wr_ent)
    );
  end

  assign tail     = chain[TABLE_DEPTH];
  assign tail_sel = sel[TABLE_DEPTH];

  always_comb begin
    fix_st   = (req.new_state == ST_RSVD) ? ST_BUSY : req.new_state;
    rsp_next = '0;
    wr_next  = 1'b0;
    app_next = 1'b0;
    idx_next = tail_sel;
    case (req.op)
      OP_UPDATE: begin
        if (tail.hit || can_app) begin
          rsp_next.status             = STATUS_OK;
          rsp_next.out_state          = fix_st;
          rsp_next.out_queue_size     = req.new_queue_size;
          rsp_next.out_memory_bytes   = req.new_memory_bytes;
          rsp_next.out_last_update_ms = req.now_ms;
          wr_next                     = 1'b1;
          if (tail.hit) begin
            rsp_next.chosen_id         = tail.ent.id;
            rsp_next.out_request_count = tail.ent.reqs + 32'd1;
          end else begin
            idx_next                   = entry_count[IDX_W-1:0];
            rsp_next.chosen_id         = req.worker_id;
            rsp_next.out_request_count = 32'd1;
            app_next                   = 1'b1;
          end
          rsp_next.entry_index = 3'(idx_next);
        end else begin
          rsp_next.status = STATUS_FULL;
        end
      end
      OP_LOOKUP, OP_PICK: begin
        if (tail.hit) begin
          rsp_next.status             = STATUS_OK;
          rsp_next.entry_index        = 3'(tail_sel);
          rsp_next.chosen_id          = tail.ent.id;
          rsp_next.out_state          = tail.ent.state;
          rsp_next.out_queue_size     = tail.ent.queue;
          rsp_next.out_memory_bytes   = tail.ent.mem;
          rsp_next.out_last_update_ms = tail.ent.last;
          rsp_next.out_request_count  = tail.ent.reqs;
        end else begin
          rsp_next.status = STATUS_NONE;
        end
      end
      default: rsp_next.status = STATUS_NONE;
    endcase
  end

  always_comb begin
    wr_en        = load && res_wr;
    wr_ent.id    = res.chosen_id;
    wr_ent.state = res.out_state;
    wr_ent.queue = res.out_queue_size;
    wr_ent.mem   = res.out_memory_bytes;
    wr_ent.last  = res.out_last_update_ms;
    wr_ent.reqs  = res.out_request_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      inj_vld     <= 1'b0;
      out_valid   <= 1'b0;
      entry_count <= '0;
      max_entries <= MAX_ENTRIES_RST;
      stale_limit <= STALE_LIMIT_RST;
    end else begin
      inj_vld <= accept;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_ENTRIES: max_entries <= cfg_data[3:0];
          CFG_STALE_LIMIT: stale_limit <= cfg_data;
          default: ;
        endcase
      end
      if (load) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (load && res_app) begin
        entry_count <= entry_count + CNT_W'(1);
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            req    <= in_data;
            live_n <= live_now;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (tail.vld) begin
            res     <= rsp_next;
            res_wr  <= wr_next;
            res_app <= app_next;
            res_idx <= idx_next;
            state   <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/wsll_checker.sv]
// ----------------------------------------------------------------------------
// wsll_checker
// Port-level checks for the worker status table, bound to the top level.
// ----------------------------------------------------------------------------
module wsll_checker (
  input logic            clk,
  input logic            rst,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input wsll_pkg::rsp_t  out_data
);
  import wsll_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != STATUS_OK) |->
      (out_data.entry_index == 3'd0) && (out_data.chosen_id == '0) &&
      (out_data.out_state == 2'd0) && (out_data.out_queue_size == 32'd0) &&
      (out_data.out_memory_bytes == 64'd0) && (out_data.out_last_update_ms == 48'd0) &&
      (out_data.out_request_count == 32'd0))
    else $error("error result carries nonzero fields");

  a_state_mapped: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == STATUS_OK) |-> out_data.out_state != ST_RSVD)
    else $error("reserved state stored");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken during sweep");

endmodule

bind worker_status_table_least_loaded_core wsll_checker u_wsll_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
